// ===== hw/rtl/rbf_pkg.sv =====
package rbf_pkg;

  localparam int SAMPLE_W = 24;
  localparam int COEF_W   = 16;
  localparam int HALF_W   = 5;
  localparam int IDX_W    = 6;
  localparam int REG_W    = 17;
  localparam int RAW_W    = 34;
  localparam int SUM_W    = 40;
  localparam int NUM_W    = 51;
  localparam int ACC_W    = 48;
  localparam int PROD_W   = 42;
  localparam int Q_W      = 17;

  localparam logic [REG_W-1:0] ONE_Q16     = 17'd65536;
  localparam logic [REG_W-1:0] PI_HALF_Q16 = 17'd102944;

  localparam logic [1:0] REG_HALF_WIDTH = 2'd0;
  localparam logic [1:0] REG_TAP_STEP   = 2'd1;
  localparam logic [1:0] REG_LIMB_COEFF = 2'd2;

  typedef logic [RAW_W-1:0] raw_t;

  typedef struct packed {
    logic             capture;
    logic             start;
    logic             shift;
    logic             raw_start;
    logic             sum_clr;
    logic             sum_add;
    logic             div_start;
    logic             w_write;
    logic             mac_clr;
    logic             mac_issue;
    logic             out_load;
    logic             out_last;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  typedef struct packed {
    logic              raw_done;
    logic              div_done;
    logic              mac_idle;
    logic              out_free;
    logic [HALF_W-1:0] h;
  } status_t;

endpackage

// ===== hw/rtl/rbf_tap.sv =====
module rbf_tap (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  input  logic [4:0]             tap_idx,
  input  logic [16:0]            step,
  input  logic [16:0]            limb,
  output logic                   done,
  output rbf_pkg::raw_t          raw
);
  import rbf_pkg::*;

  localparam logic [2:0] T_IDLE = 3'd0;
  localparam logic [2:0] T_SQ   = 3'd1;
  localparam logic [2:0] T_SQRT = 3'd2;
  localparam logic [2:0] T_LIN  = 3'd3;
  localparam logic [2:0] T_FIN  = 3'd4;

  logic [2:0]  ph;
  logic [21:0] x;
  logic [32:0] u;
  logic [32:0] u_c;
  logic [32:0] v;
  logic [33:0] res;
  logic [33:0] bitr;
  logic [33:0] trial;
  logic [33:0] p1;
  logic [50:0] p2;
  logic [33:0] linp;

  // One minus x squared, forced to zero once x reaches one.
  assign u_c = (|x[21:16]) ? 33'd0 :
               (33'h1_0000_0000 - ({17'd0, x[15:0]} * {17'd0, x[15:0]}));
  assign trial = res + bitr;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph   <= T_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (ph)
        T_IDLE: begin
          if (start) begin
            x  <= {17'd0, tap_idx} * {5'd0, step};
            ph <= T_SQ;
          end
        end
        T_SQ: begin
          u    <= u_c;
          v    <= u_c;
          res  <= '0;
          bitr <= 34'h1_0000_0000;
          ph   <= T_SQRT;
        end
        T_SQRT: begin
          p1 <= {17'd0, limb} * {1'b0, u[32:16]};
          p2 <= {17'd0, p1} * {34'd0, PI_HALF_Q16};
          if (bitr != '0) begin
            if ({1'b0, v} >= trial) begin
              v   <= v - trial[32:0];
              res <= (res >> 1) + bitr;
            end else begin
              res <= res >> 1;
            end
            bitr <= bitr >> 2;
          end else begin
            ph <= T_LIN;
          end
        end
        T_LIN: begin
          linp <= {17'd0, ONE_Q16 - limb} * {17'd0, res[16:0]};
          ph   <= T_FIN;
        end
        T_FIN: begin
          raw  <= {linp[32:0], 1'b0} + p2[49:16];
          done <= 1'b1;
          ph   <= T_IDLE;
        end
        default: ph <= T_IDLE;
      endcase
    end
  end

endmodule

// ===== hw/rtl/rbf_div.sv =====
module rbf_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [50:0] num,
  input  logic [39:0] den,
  output logic        done,
  output logic [16:0] quo
);
  import rbf_pkg::*;

  logic        busy;
  logic [4:0]  cnt;
  logic [40:0] rem;
  logic [40:0] rem2;
  logic [16:0] nlow;

  assign rem2 = {rem[39:0], nlow[16]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // The quotient fits in 17 bits, so the upper part is below den.
        rem  <= {7'd0, num[50:17]};
        nlow <= num[16:0];
        cnt  <= 5'd17;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem2 >= {1'b0, den}) begin
          rem <= rem2 - {1'b0, den};
          quo <= {quo[15:0], 1'b1};
        end else begin
          rem <= rem2;
          quo <= {quo[15:0], 1'b0};
        end
        nlow <= {nlow[15:0], 1'b0};
        cnt  <= cnt - 5'd1;
        if (cnt == 5'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/rbf_datapath.sv =====
module rbf_datapath (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [16:0]      cfg_data,
  input  logic [23:0]      sample,
  input  rbf_pkg::cmd_t    cmd,
  output rbf_pkg::status_t st,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [23:0]      value,
  output logic             last_res
);
  import rbf_pkg::*;

  localparam logic signed [ACC_W-1:0] SMAX = 48'sd8388607;
  localparam logic signed [ACC_W-1:0] SMIN = -48'sd8388608;
  localparam logic signed [ACC_W-1:0] HALF_LSB = 48'sd32768;

  logic [HALF_W-1:0]   cfg_half;
  logic [REG_W-1:0]    cfg_step;
  logic [REG_W-1:0]    cfg_limb;
  logic [REG_W-1:0]    limb_c;
  logic [SAMPLE_W-1:0] s_reg;
  logic [SAMPLE_W-1:0] first_s;
  logic [HALF_W-1:0]   h_lat;
  logic [IDX_W-1:0]    wptr;
  logic [IDX_W-1:0]    fill;
  logic [SUM_W-1:0]    sum;
  logic signed [ACC_W-1:0]  acc;
  logic signed [PROD_W-1:0] prod;
  logic                v1;
  logic                v2;
  logic                rep1;
  logic [SAMPLE_W-1:0] rd_s;
  logic [Q_W-1:0]      rd_w;
  logic [SAMPLE_W-1:0] sel_s;
  logic [IDX_W-1:0]    wi;
  logic [IDX_W-1:0]    hx;

  logic [SAMPLE_W-1:0] win [64];
  logic [Q_W-1:0]      wmem [32];

  logic                raw_done;
  raw_t                raw;
  logic                div_done;
  logic [Q_W-1:0]      quo;
  logic [NUM_W-1:0]    num;
  logic signed [ACC_W-1:0] rnd;

  assign limb_c = (cfg_limb[16] && (|cfg_limb[15:0])) ? ONE_Q16 : cfg_limb;
  assign num    = {1'b0, raw, 16'd0} + {12'd0, sum[SUM_W-1:1]};
  assign hx     = {1'b0, h_lat};
  assign wi     = (cmd.idx >= hx) ? (cmd.idx - hx) : (hx - cmd.idx);
  assign sel_s  = rep1 ? first_s : rd_s;
  assign rnd    = (acc + HALF_LSB) >>> COEF_W;

  rbf_tap u_tap (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.raw_start),
    .tap_idx (cmd.idx[4:0]),
    .step    (cfg_step),
    .limb    (limb_c),
    .done    (raw_done),
    .raw     (raw)
  );

  rbf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (num),
    .den   (sum),
    .done  (div_done),
    .quo   (quo)
  );

  always_ff @(posedge clk) begin
    if (cmd.shift) begin
      win[wptr + 6'd1] <= s_reg;
    end
    if (cmd.mac_issue) begin
      rd_s <= win[wptr - cmd.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.w_write) begin
      wmem[cmd.idx[4:0]] <= quo;
    end
    if (cmd.mac_issue) begin
      rd_w <= wmem[wi[4:0]];
    end
  end

  always_ff @(posedge clk) begin
    prod <= $signed({1'b0, rd_w}) * $signed(sel_s);
    if (cmd.capture) begin
      s_reg <= sample;
    end
    if (cmd.start) begin
      first_s <= sample;
    end
    if (cmd.mac_issue) begin
      rep1 <= (cmd.idx >= fill);
    end
    if (cmd.sum_clr) begin
      sum <= '0;
    end else if (cmd.sum_add) begin
      sum <= sum + ((cmd.idx != '0) ? {5'd0, raw, 1'b0} : {6'd0, raw});
    end
    if (cmd.mac_clr) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + ACC_W'(prod);
    end
    if (cmd.out_load) begin
      last_res <= cmd.out_last;
      if (rnd > SMAX) begin
        value <= SMAX[SAMPLE_W-1:0];
      end else if (rnd < SMIN) begin
        value <= SMIN[SAMPLE_W-1:0];
      end else begin
        value <= rnd[SAMPLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_half  <= '0;
      cfg_step  <= ONE_Q16;
      cfg_limb  <= '0;
      h_lat     <= '0;
      wptr      <= '0;
      fill      <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_HALF_WIDTH: cfg_half <= cfg_data[HALF_W-1:0];
          REG_TAP_STEP:   cfg_step <= cfg_data;
          REG_LIMB_COEFF: cfg_limb <= cfg_data;
          default: ;
        endcase
      end
      // Entries at or beyond the fill count read as the first sample.
      if (cmd.start) begin
        h_lat <= cfg_half;
        fill  <= '0;
      end else if (cmd.shift) begin
        wptr <= wptr + 6'd1;
        if (fill != 6'd63) begin
          fill <= fill + 6'd1;
        end
      end
      v1 <= cmd.mac_issue;
      v2 <= v1;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign st.raw_done = raw_done;
  assign st.div_done = div_done;
  assign st.mac_idle = !v1 && !v2;
  assign st.out_free = !out_valid || out_ready;
  assign st.h        = h_lat;

endmodule

// ===== hw/rtl/rbf_ctrl.sv =====
module rbf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_last,
  output logic             in_ready,
  input  rbf_pkg::status_t st,
  output rbf_pkg::cmd_t    cmd
);
  import rbf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RAW1  = 4'd1;
  localparam logic [3:0] S_WRAW1 = 4'd2;
  localparam logic [3:0] S_RAW2  = 4'd3;
  localparam logic [3:0] S_WRAW2 = 4'd4;
  localparam logic [3:0] S_WDIV  = 4'd5;
  localparam logic [3:0] S_SHIFT = 4'd6;
  localparam logic [3:0] S_ECHK  = 4'd7;
  localparam logic [3:0] S_MAC   = 4'd8;
  localparam logic [3:0] S_MWAIT = 4'd9;
  localparam logic [3:0] S_OUTW  = 4'd10;
  localparam logic [3:0] S_NEXT  = 4'd11;

  logic [3:0]        state;
  logic [3:0]        state_next;
  logic              in_spec;
  logic [5:0]        seen;
  logic [5:0]        n_cur;
  logic              last_r;
  logic              flushing;
  logic [HALF_W-1:0] m;
  logic [HALF_W-1:0] d;
  logic [IDX_W-1:0]  t;
  logic              accept;
  logic              emit;
  logic              d_end;
  logic              t_end;
  logic              m_end;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign emit     = ({1'b0, n_cur} + (flushing ? {2'b0, m} : 7'd0)) >= {2'b0, st.h};
  assign d_end    = (d == st.h);
  assign t_end    = (t == {st.h, 1'b0});
  assign m_end    = (m == st.h);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.capture = 1'b1;
          if (!in_spec) begin
            cmd.start   = 1'b1;
            cmd.sum_clr = 1'b1;
            state_next  = S_RAW1;
          end else begin
            state_next = S_SHIFT;
          end
        end
      end
      S_RAW1: begin
        cmd.raw_start = 1'b1;
        cmd.idx       = {1'b0, d};
        state_next    = S_WRAW1;
      end
      S_WRAW1: begin
        cmd.idx = {1'b0, d};
        if (st.raw_done) begin
          cmd.sum_add = 1'b1;
          state_next  = d_end ? S_RAW2 : S_RAW1;
        end
      end
      S_RAW2: begin
        cmd.raw_start = 1'b1;
        cmd.idx       = {1'b0, d};
        state_next    = S_WRAW2;
      end
      S_WRAW2: begin
        if (st.raw_done) begin
          cmd.div_start = 1'b1;
          state_next    = S_WDIV;
        end
      end
      S_WDIV: begin
        cmd.idx = {1'b0, d};
        if (st.div_done) begin
          cmd.w_write = 1'b1;
          state_next  = d_end ? S_ECHK : S_RAW2;
        end
      end
      S_SHIFT: begin
        cmd.shift  = 1'b1;
        state_next = S_ECHK;
      end
      S_ECHK: begin
        if (emit) begin
          cmd.mac_clr = 1'b1;
          state_next  = S_MAC;
        end else begin
          state_next = S_NEXT;
        end
      end
      S_MAC: begin
        cmd.mac_issue = 1'b1;
        cmd.idx       = t;
        if (t_end) begin
          state_next = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (st.mac_idle) begin
          state_next = S_OUTW;
        end
      end
      S_OUTW: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = flushing ? m_end : (last_r && (st.h == '0));
          state_next   = S_NEXT;
        end
      end
      S_NEXT: begin
        if (!last_r || (st.h == '0) || (flushing && m_end)) begin
          state_next = S_IDLE;
        end else begin
          // Each flush step shifts the last sample in once more.
          cmd.shift  = 1'b1;
          state_next = S_ECHK;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      in_spec  <= 1'b0;
      seen     <= '0;
      n_cur    <= '0;
      last_r   <= 1'b0;
      flushing <= 1'b0;
      m        <= '0;
      d        <= '0;
      t        <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_r   <= in_last;
            flushing <= 1'b0;
            m        <= '0;
            d        <= '0;
            if (!in_spec) begin
              in_spec <= 1'b1;
              n_cur   <= '0;
              seen    <= 6'd1;
            end else begin
              n_cur <= seen;
              if (seen != 6'd63) begin
                seen <= seen + 6'd1;
              end
            end
          end
        end
        S_WRAW1: begin
          if (st.raw_done) begin
            d <= d_end ? '0 : d + 5'd1;
          end
        end
        S_WDIV: begin
          if (st.div_done && !d_end) begin
            d <= d + 5'd1;
          end
        end
        S_ECHK: begin
          t <= '0;
        end
        S_MAC: begin
          t <= t + 6'd1;
        end
        S_NEXT: begin
          if (!last_r || (st.h == '0) || (flushing && m_end)) begin
            if (last_r) begin
              in_spec <= 1'b0;
              seen    <= '0;
            end
          end else begin
            flushing <= 1'b1;
            m        <= m + 5'd1;
          end
        end
        default: ;
      endcase
    end
  end

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> st.out_free)
    else $error("result loaded while the output register was still full");

  a_tap_range: assert property (@(posedge clk) disable iff (rst)
    cmd.mac_issue |-> (cmd.idx <= {st.h, 1'b0}))
    else $error("tap index beyond the kernel span");

  a_raw_wait: assert property (@(posedge clk) disable iff (rst)
    st.raw_done |-> (state == S_WRAW1 || state == S_WRAW2))
    else $error("tap value finished outside a wait state");

  a_flush_bound: assert property (@(posedge clk) disable iff (rst)
    flushing |-> (m <= st.h))
    else $error("flush ran past the half width");

endmodule

// ===== hw/rtl/rotational_broadening_fir_core.sv =====
// Channel   Direction  Handshake             Payload
// config    in         cfg_we                cfg_index, cfg_data
// input     in         in_valid / in_ready   sample, last
// output    out        out_valid / out_ready value, last_res
//
// The first beat of a spectrum builds the kernel: two passes over the h+1 taps,
// one for the sum and one for the normalizing division, each tap paced by the
// iterative square root and, in the second pass, also by the divider.
// Each result then runs on the single multiply-accumulate, after its beat is
// accepted and shifted in; a final beat adds up to h such results.
// Reset is synchronous.
// A stalled output register holds the controller before it loads the next result.
module rotational_broadening_fir_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [23:0] sample,
  input  logic        last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [23:0] value,
  output logic        last_res
);
  import rbf_pkg::*;

  cmd_t    cmd;
  status_t st;

  rbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_last  (last),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  rbf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .last_res  (last_res)
  );

endmodule
